/* hw/rtl/assert_macros.svh */
// assertion macros shared by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous reset disable
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

/* hw/rtl/bba_pkg.sv */
// package for the buddy block allocator: sizes, codes and request types
package bba_pkg;

  localparam int POOL_ORDER     = 10;
  localparam int MIN_BLOCK_LOG2 = 4;

  localparam int UNIT_W     = POOL_ORDER;
  localparam int NODE_W     = POOL_ORDER + 1;
  localparam int ORD_W      = 4;
  localparam int ROW_LOG2   = 6;
  localparam int ROW_W      = 1 << ROW_LOG2;
  localparam int NODE_ROWS  = (2 << POOL_ORDER) / ROW_W;
  localparam int LIVE_ROWS  = (1 << POOL_ORDER) / ROW_W;
  localparam int MAP_ROWS   = NODE_ROWS + LIVE_ROWS;
  localparam int NROW_W     = $clog2(NODE_ROWS);
  localparam int LROW_W     = $clog2(LIVE_ROWS);
  localparam int MROW_W     = $clog2(MAP_ROWS);
  localparam int ADDR_W     = 14;
  localparam int BYTES_W    = 15;
  localparam int HDR_W      = 7;
  localparam int TOTAL_W    = BYTES_W + 1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NO_SPACE = 3'd2,
    ST_TOO_BIG  = 3'd3,
    ST_NOT_LIVE = 3'd4
  } status_e;

  typedef struct packed {
    op_e                opcode;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;
  } bba_req_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] granted_address;
    logic [ORD_W-1:0]  granted_order;
  } bba_rsp_t;

endpackage

/* hw/rtl/bba_ram.sv */
// generic single-port-write ram with registered read
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/buddy_block_allocator.sv */
// buddy block allocator: node and live maps share one ram, order store in another
// zero size, oversize or misalignment finish straight from idle; free reads the live map
// (not live ends there), then merges with each free buddy; alloc scans node-map rows (one row
//   per level for small levels), then splits; each row goes through the single read port of the map ram
// one request at a time; busy high while one is in work
// reset: only root free, no live blocks, header 0; row valid bits stand in for a clear
`include "assert_macros.svh"

module buddy_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bba_pkg::bba_req_t         req_i,
  output logic                      done_o,
  output bba_pkg::bba_rsp_t         rsp_o,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::HDR_W-1:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_RD, S_SPLIT_WR, S_UNIT,
    S_LIVE_RD, S_LIVE_WR, S_FREE_RD, S_FREE_CHK, S_MERGE_RD, S_MERGE_CHK
  } state_e;

  state_e                         state_q;
  logic [bba_pkg::HDR_W-1:0]      hdr_q;
  logic [bba_pkg::NODE_W-1:0]     n_q;
  logic [bba_pkg::ORD_W-1:0]      o_q, k_q;
  logic [bba_pkg::NROW_W-1:0]     row_q;
  logic [bba_pkg::UNIT_W-1:0]     unit_q;
  logic [bba_pkg::NODE_ROWS-1:0]  nvalid_q;
  logic [bba_pkg::LIVE_ROWS-1:0]  lvalid_q;
  logic                           done_q;
  bba_pkg::bba_rsp_t              rsp_q;

  logic                           nwe, lwe, owe;
  logic [bba_pkg::NROW_W-1:0]     nraddr;
  logic [bba_pkg::MROW_W-1:0]     map_raddr, map_waddr, lrow_addr;
  logic [bba_pkg::ROW_W-1:0]      map_wdata;
  logic [bba_pkg::ROW_W-1:0]      nwdata, nrdata, nrow, lvl_mask, lwdata, lrow;
  logic [bba_pkg::ORD_W-1:0]      ordata, kk, kfree, lvl;
  logic [bba_pkg::TOTAL_W-1:0]    total;
  logic [bba_pkg::ROW_LOG2-1:0]   hit_bit;
  logic                           hit;
  logic [bba_pkg::NODE_W-1:0]     split_tgt, node_off, free_node;
  logic [bba_pkg::UNIT_W-1:0]     unit_calc;

  function automatic logic [bba_pkg::NROW_W-1:0] first_row(input logic [bba_pkg::ORD_W-1:0] o);
    int unsigned f;
    f = 1 << (bba_pkg::POOL_ORDER - int'(o));
    return bba_pkg::NROW_W'(f >> bba_pkg::ROW_LOG2);
  endfunction

  function automatic logic [bba_pkg::NROW_W-1:0] last_row(input logic [bba_pkg::ORD_W-1:0] o);
    int unsigned f;
    f = (2 << (bba_pkg::POOL_ORDER - int'(o))) - 1;
    return bba_pkg::NROW_W'(f >> bba_pkg::ROW_LOG2);
  endfunction

  // node map rows first, live map rows above them
  assign lrow_addr = bba_pkg::MROW_W'(bba_pkg::NODE_ROWS)
                   + bba_pkg::MROW_W'(unit_q[bba_pkg::UNIT_W-1:bba_pkg::ROW_LOG2]);
  assign map_waddr = lwe ? lrow_addr : bba_pkg::MROW_W'(row_q);
  assign map_wdata = lwe ? lwdata : nwdata;
  assign map_raddr = (state_q == S_LIVE_RD || state_q == S_FREE_RD) ? lrow_addr
                   : bba_pkg::MROW_W'(nraddr);

  bba_ram #(.WIDTH(bba_pkg::ROW_W), .DEPTH(bba_pkg::MAP_ROWS)) u_map_ram (
    .clk_i, .we_i(nwe | lwe), .waddr_i(map_waddr), .wdata_i(map_wdata),
    .raddr_i(map_raddr), .rdata_o(nrdata)
  );

  bba_ram #(.WIDTH(bba_pkg::ORD_W), .DEPTH(1 << bba_pkg::UNIT_W)) u_order_ram (
    .clk_i, .we_i(owe), .waddr_i(unit_q), .wdata_i(k_q), .raddr_i(unit_q), .rdata_o(ordata)
  );

  // rows never written read as their reset contents
  assign nrow = nvalid_q[row_q] ? nrdata
              : ((row_q == '0) ? bba_pkg::ROW_W'(2) : '0);
  assign lrow = lvalid_q[unit_q[bba_pkg::UNIT_W-1:bba_pkg::ROW_LOG2]] ? nrdata : '0;

  assign total = bba_pkg::TOTAL_W'(req_i.request_bytes) + bba_pkg::TOTAL_W'(hdr_q);

  always_comb begin
    kk = bba_pkg::ORD_W'(bba_pkg::POOL_ORDER + 1);
    for (int i = bba_pkg::POOL_ORDER; i >= 0; i--) begin
      if ((64'd1 << (bba_pkg::MIN_BLOCK_LOG2 + i)) >= 64'(total)) begin
        kk = bba_pkg::ORD_W'(i);
      end
    end
  end

  assign lvl = bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) - o_q;

  always_comb begin
    for (int b = 0; b < bba_pkg::ROW_W; b++) begin
      lvl_mask[b] = (({row_q, bba_pkg::ROW_LOG2'(b)} >> lvl) == bba_pkg::NODE_W'(1));
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = bba_pkg::ROW_W - 1; b >= 0; b--) begin
      if (nrow[b] && lvl_mask[b]) begin
        hit     = 1'b1;
        hit_bit = bba_pkg::ROW_LOG2'(b);
      end
    end
  end

  assign split_tgt = {n_q[bba_pkg::NODE_W-2:0], 1'b1};
  assign node_off  = n_q & ~(bba_pkg::NODE_W'(1) << (bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) - k_q));
  assign unit_calc = bba_pkg::UNIT_W'(node_off << k_q);
  assign kfree     = (ordata > bba_pkg::ORD_W'(bba_pkg::POOL_ORDER))
                   ? bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) : ordata;
  assign free_node = (bba_pkg::NODE_W'(1) << (bba_pkg::ORD_W'(bba_pkg::POOL_ORDER) - kfree))
                   | bba_pkg::NODE_W'(unit_q >> kfree);

  always_comb begin
    nwe    = 1'b0;
    lwe    = 1'b0;
    owe    = 1'b0;
    nraddr = row_q;
    nwdata = nrow;
    lwdata = lrow;
    case (state_q)
      S_SCAN_CHK: begin
        nwe    = hit;
        nwdata = nrow & ~(bba_pkg::ROW_W'(1) << hit_bit);
      end
      S_SPLIT_RD: begin
        nraddr = split_tgt[bba_pkg::NODE_W-1:bba_pkg::ROW_LOG2];
      end
      S_SPLIT_WR: begin
        nwe    = 1'b1;
        nwdata = nrow | (bba_pkg::ROW_W'(1) << split_tgt[bba_pkg::ROW_LOG2-1:0]);
      end
      S_LIVE_WR: begin
        lwe    = 1'b1;
        owe    = 1'b1;
        lwdata = lrow | (bba_pkg::ROW_W'(1) << unit_q[bba_pkg::ROW_LOG2-1:0]);
      end
      S_FREE_CHK: begin
        lwe    = lrow[unit_q[bba_pkg::ROW_LOG2-1:0]];
        lwdata = lrow & ~(bba_pkg::ROW_W'(1) << unit_q[bba_pkg::ROW_LOG2-1:0]);
      end
      S_MERGE_RD: begin
        nraddr = n_q[bba_pkg::NODE_W-1:bba_pkg::ROW_LOG2];
      end
      S_MERGE_CHK: begin
        nwe = 1'b1;
        if (n_q != bba_pkg::NODE_W'(1) && nrow[n_q[bba_pkg::ROW_LOG2-1:0] ^ 1'b1]) begin
          nwdata = nrow & ~(bba_pkg::ROW_W'(1) << (n_q[bba_pkg::ROW_LOG2-1:0] ^ 1'b1));
        end else begin
          nwdata = nrow | (bba_pkg::ROW_W'(1) << n_q[bba_pkg::ROW_LOG2-1:0]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hdr_q    <= '0;
      nvalid_q <= '0;
      lvalid_q <= '0;
      done_q   <= 1'b0;
      rsp_q    <= '0;
      n_q      <= '0;
      o_q      <= '0;
      k_q      <= '0;
      row_q    <= '0;
      unit_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        hdr_q <= cfg_wdata_i;
      end
      if (nwe) begin
        nvalid_q[row_q] <= 1'b1;
      end
      if (lwe) begin
        lvalid_q[unit_q[bba_pkg::UNIT_W-1:bba_pkg::ROW_LOG2]] <= 1'b1;
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            rsp_q <= '0;
            if (req_i.opcode == bba_pkg::OP_ALLOC) begin
              if (req_i.request_bytes == '0) begin
                done_q       <= 1'b1;
                rsp_q.status <= bba_pkg::ST_ZERO;
              end else if (kk > bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) begin
                done_q       <= 1'b1;
                rsp_q.status <= bba_pkg::ST_TOO_BIG;
              end else begin
                k_q     <= kk;
                o_q     <= kk;
                row_q   <= first_row(kk);
                state_q <= S_SCAN_RD;
              end
            end else if (req_i.block_address[bba_pkg::MIN_BLOCK_LOG2-1:0] != '0) begin
              done_q       <= 1'b1;
              rsp_q.status <= bba_pkg::ST_NOT_LIVE;
            end else begin
              unit_q  <= req_i.block_address[bba_pkg::ADDR_W-1:bba_pkg::MIN_BLOCK_LOG2];
              state_q <= S_FREE_RD;
            end
          end
        end
        S_SCAN_RD: state_q <= S_SCAN_CHK;
        S_SCAN_CHK: begin
          if (hit) begin
            n_q     <= {row_q, hit_bit};
            state_q <= (o_q > k_q) ? S_SPLIT_RD : S_UNIT;
          end else if (row_q != last_row(o_q)) begin
            row_q   <= row_q + 1'b1;
            state_q <= S_SCAN_RD;
          end else if (o_q == bba_pkg::ORD_W'(bba_pkg::POOL_ORDER)) begin
            done_q       <= 1'b1;
            rsp_q.status <= bba_pkg::ST_NO_SPACE;
            state_q      <= S_IDLE;
          end else begin
            o_q     <= o_q + 1'b1;
            row_q   <= first_row(o_q + 1'b1);
            state_q <= S_SCAN_RD;
          end
        end
        S_SPLIT_RD: begin
          row_q   <= split_tgt[bba_pkg::NODE_W-1:bba_pkg::ROW_LOG2];
          state_q <= S_SPLIT_WR;
        end
        S_SPLIT_WR: begin
          n_q     <= {n_q[bba_pkg::NODE_W-2:0], 1'b0};
          o_q     <= o_q - 1'b1;
          state_q <= (o_q - 1'b1 > k_q) ? S_SPLIT_RD : S_UNIT;
        end
        S_UNIT: begin
          unit_q  <= unit_calc;
          state_q <= S_LIVE_RD;
        end
        S_LIVE_RD: state_q <= S_LIVE_WR;
        S_LIVE_WR: begin
          done_q                <= 1'b1;
          rsp_q.status          <= bba_pkg::ST_OK;
          rsp_q.granted_address <= {unit_q, bba_pkg::MIN_BLOCK_LOG2'(0)};
          rsp_q.granted_order   <= k_q;
          state_q               <= S_IDLE;
        end
        S_FREE_RD: state_q <= S_FREE_CHK;
        S_FREE_CHK: begin
          if (!lrow[unit_q[bba_pkg::ROW_LOG2-1:0]]) begin
            done_q       <= 1'b1;
            rsp_q.status <= bba_pkg::ST_NOT_LIVE;
            state_q      <= S_IDLE;
          end else begin
            n_q     <= free_node;
            state_q <= S_MERGE_RD;
          end
        end
        S_MERGE_RD: begin
          row_q   <= n_q[bba_pkg::NODE_W-1:bba_pkg::ROW_LOG2];
          state_q <= S_MERGE_CHK;
        end
        S_MERGE_CHK: begin
          if (n_q != bba_pkg::NODE_W'(1) && nrow[n_q[bba_pkg::ROW_LOG2-1:0] ^ 1'b1]) begin
            n_q     <= n_q >> 1;
            state_q <= S_MERGE_RD;
          end else begin
            done_q       <= 1'b1;
            rsp_q.status <= bba_pkg::ST_OK;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `BBA_ASSERT(a_done_idle, done_o |-> !busy, "result while busy")
  `BBA_ASSERT(a_start_moves, start && !busy |=> busy || done_o, "request accepted but ignored")
  `BBA_ASSERT(a_err_zero, done_o && rsp_o.status != bba_pkg::ST_OK |-> rsp_o.granted_address == '0 && rsp_o.granted_order == '0, "error with nonzero grant")
  `BBA_ASSERT(a_order_range, done_o |-> rsp_o.granted_order <= bba_pkg::ORD_W'(bba_pkg::POOL_ORDER), "granted order out of range")

endmodule

/* verif/tb_top.sv */
// testbench for the buddy block allocator: directed and random requests against a local model
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UNITS = 1 << bba_pkg::POOL_ORDER;
  localparam int NODES = 2 << bba_pkg::POOL_ORDER;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  bba_pkg::bba_req_t req_i = '0;
  logic done_o;
  bba_pkg::bba_rsp_t rsp_o;
  logic cfg_we_i = 1'b0;
  logic [bba_pkg::HDR_W-1:0] cfg_wdata_i = '0;

  buddy_block_allocator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  bit node_map[NODES];
  logic [bba_pkg::ORD_W-1:0] block_order[UNITS];
  bit block_live[UNITS];
  int unsigned hdr_bytes;
  bba_pkg::bba_rsp_t grant_q[$];
  logic [bba_pkg::ADDR_W-1:0] live_addr_q[$];
  int errors;
  int idle_cycles;

  function automatic bba_pkg::bba_rsp_t predict_request(bba_pkg::bba_req_t rq);
    bba_pkg::bba_rsp_t r;
    int unsigned total, k, o, n, unit, first;
    bit found;
    r = '0;
    r.status = bba_pkg::ST_OK;
    found = 0;
    n = 0;
    if (rq.opcode == bba_pkg::OP_ALLOC) begin
      if (rq.request_bytes == 0) begin
        r.status = bba_pkg::ST_ZERO;
        return r;
      end
      total = rq.request_bytes + hdr_bytes;
      k = 0;
      while (k <= bba_pkg::POOL_ORDER && (1 << (bba_pkg::MIN_BLOCK_LOG2 + k)) < total) k++;
      if (k > bba_pkg::POOL_ORDER) begin
        r.status = bba_pkg::ST_TOO_BIG;
        return r;
      end
      for (o = k; o <= bba_pkg::POOL_ORDER && !found; o++) begin
        first = 1 << (bba_pkg::POOL_ORDER - o);
        for (n = first; n < 2 * first; n++)
          if (node_map[n]) begin
            found = 1;
            break;
          end
      end
      if (!found) begin
        r.status = bba_pkg::ST_NO_SPACE;
        return r;
      end
      o--;
      node_map[n] = 0;
      while (o > k) begin
        o--;
        n = n << 1;
        node_map[n + 1] = 1;
      end
      unit = (n - (1 << (bba_pkg::POOL_ORDER - k))) << k;
      block_live[unit] = 1;
      block_order[unit] = bba_pkg::ORD_W'(k);
      r.granted_address = bba_pkg::ADDR_W'(unit << bba_pkg::MIN_BLOCK_LOG2);
      r.granted_order = bba_pkg::ORD_W'(k);
      live_addr_q.push_back(r.granted_address);
    end else begin
      unit = rq.block_address >> bba_pkg::MIN_BLOCK_LOG2;
      if ((rq.block_address & ((1 << bba_pkg::MIN_BLOCK_LOG2) - 1)) != 0
          || !block_live[unit]) begin
        r.status = bba_pkg::ST_NOT_LIVE;
        return r;
      end
      k = block_order[unit];
      block_live[unit] = 0;
      n = (1 << (bba_pkg::POOL_ORDER - k)) + (unit >> k);
      while (n > 1 && node_map[n ^ 1]) begin
        node_map[n ^ 1] = 0;
        n = n >> 1;
      end
      node_map[n] = 1;
    end
    return r;
  endfunction

  task automatic send_request(bba_pkg::op_e op, int unsigned bytes, int unsigned addr);
    bba_pkg::bba_req_t rq;
    int gap;
    rq.opcode = op;
    rq.request_bytes = bba_pkg::BYTES_W'(bytes);
    rq.block_address = bba_pkg::ADDR_W'(addr);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    grant_q.push_back(predict_request(rq));
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_header(int unsigned v);
    drain_requests();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= bba_pkg::HDR_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_bytes = v;
  endtask

  task automatic free_live(int idx);
    logic [bba_pkg::ADDR_W-1:0] a;
    a = live_addr_q[idx];
    live_addr_q.delete(idx);
    send_request(bba_pkg::OP_FREE, $urandom, a);
  endtask

  task automatic test_errors();
    send_request(bba_pkg::OP_ALLOC, 0, 0);
    send_request(bba_pkg::OP_ALLOC, 16384, 0);
    send_request(bba_pkg::OP_ALLOC, 32767, 0);
    send_request(bba_pkg::OP_FREE, 0, 0);
    send_request(bba_pkg::OP_FREE, 0, 16383);
    send_request(bba_pkg::OP_FREE, 0, 8);
  endtask

  task automatic test_split_merge();
    send_request(bba_pkg::OP_ALLOC, 1, 0);
    send_request(bba_pkg::OP_ALLOC, 16, 0);
    send_request(bba_pkg::OP_ALLOC, 17, 0);
    send_request(bba_pkg::OP_FREE, 0, 16);
    send_request(bba_pkg::OP_FREE, 0, 16);
    send_request(bba_pkg::OP_FREE, 0, 64);
    send_request(bba_pkg::OP_ALLOC, 16384, 0);
    send_request(bba_pkg::OP_ALLOC, 1, 0);
    send_request(bba_pkg::OP_FREE, 0, 0);
    send_request(bba_pkg::OP_FREE, 0, 32);
    send_request(bba_pkg::OP_FREE, 0, 0);
    live_addr_q.delete();
    send_request(bba_pkg::OP_ALLOC, 16384, 0);
    send_request(bba_pkg::OP_FREE, 0, 0);
    live_addr_q.delete();
  endtask

  task automatic test_header();
    write_header(64);
    send_request(bba_pkg::OP_ALLOC, 16320, 0);
    send_request(bba_pkg::OP_ALLOC, 16321, 0);
    send_request(bba_pkg::OP_FREE, 0, 0);
    live_addr_q.delete();
    write_header(1);
    send_request(bba_pkg::OP_ALLOC, 15, 0);
    send_request(bba_pkg::OP_ALLOC, 16, 0);
    while (live_addr_q.size() != 0) free_live(0);
  endtask

  task automatic test_random(int count);
    int unsigned sel, bytes;
    for (int i = 0; i < count; i++) begin
      if (i % 300 == 299) write_header($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 64));
      if (i == count / 2) drain_requests();
      sel = $urandom_range(0, 99);
      if (sel < 50 || live_addr_q.size() == 0) begin
        case ($urandom_range(0, 9))
          0: bytes = $urandom_range(0, 32767);
          1: bytes = $urandom_range(1024, 16384);
          default: bytes = $urandom_range(1, 1 << $urandom_range(1, 10));
        endcase
        send_request(bba_pkg::OP_ALLOC, bytes, $urandom);
      end else if (sel < 90) begin
        free_live($urandom_range(0, live_addr_q.size() - 1));
      end else begin
        send_request(bba_pkg::OP_FREE, $urandom, $urandom);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (done_o) begin
      if (grant_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        if (rsp_o.status !== grant_q[0].status) begin
          $error("status expected %0d actual %0d", grant_q[0].status, rsp_o.status);
          errors++;
        end
        if (rsp_o.granted_address !== grant_q[0].granted_address) begin
          $error("granted_address expected %0d actual %0d",
                 grant_q[0].granted_address, rsp_o.granted_address);
          errors++;
        end
        if (rsp_o.granted_order !== grant_q[0].granted_order) begin
          $error("granted_order expected %0d actual %0d",
                 grant_q[0].granted_order, rsp_o.granted_order);
          errors++;
        end
        void'(grant_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (done_o || (start && !busy) || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    hdr_bytes = 0;
    foreach (node_map[i]) node_map[i] = 0;
    foreach (block_live[i]) block_live[i] = 0;
    foreach (block_order[i]) block_order[i] = '0;
    node_map[1] = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_errors();
    test_split_merge();
    test_header();
    write_header(0);
    test_random(1180);
    drain_requests();
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end
endmodule
